// ===== rtl/sdss_pkg.sv =====
// ----------------------------------------------------------------------------
// sdss_pkg
// Shared types, constants and conversion functions for the six-digit
// seven-segment scanner.
// ----------------------------------------------------------------------------
package sdss_pkg;

   localparam int NUM_DIGITS = 6;
   localparam int CODE_W     = 5;
   localparam int SEG_W      = 8;
   localparam int NUM_CODES  = 17;

   typedef enum logic [1:0] {
      OP_TICK       = 2'd0,
      OP_FOUR_TWO   = 2'd1,
      OP_THREE_THREE = 2'd2,
      OP_BLANK_ZERO = 2'd3
   } op_type;

   typedef logic [CODE_W-1:0]               code_type;
   typedef logic [NUM_DIGITS-1:0][CODE_W-1:0] code_vec_type;
   typedef logic [NUM_DIGITS-1:0]           mask_type;
   typedef logic [SEG_W-1:0]                seg_type;

   localparam code_type BLANK_CODE = 5'd12;
   localparam seg_type  POINT_BIT  = 8'h08;
   localparam mask_type ALL_OFF    = 6'h3F;

   // Digits shown after reset: P - 1 6 1 0.
   localparam code_vec_type RESET_CODES = {5'd0, 5'd1, 5'd6, 5'd1, 5'd15, 5'd14};

   localparam seg_type SEG_TABLE [NUM_CODES] = '{
      8'hF5, 8'h05, 8'hB3, 8'h97, 8'h47, 8'hD6, 8'hF6, 8'h85, 8'hF7, 8'hD7,
      8'h75, 8'h9F, 8'h00, 8'hDE, 8'hE3, 8'h02, 8'hE7
   };

   // Load transaction travelling from the converter to the digit cells.
   typedef struct packed {
      logic         load;
      code_vec_type codes;
      mask_type     dots;
   } load_type;

   function automatic seg_type seg_decode(input code_type code);
      seg_type seg;
      seg = 8'h00;
      if (code < code_type'(NUM_CODES)) begin
         seg = SEG_TABLE[code];
      end
      return seg;
   endfunction

   // Quotient by 100 for values up to 9999, by reciprocal multiplication.
   function automatic logic [6:0] div100(input logic [13:0] x);
      logic [26:0] p;
      p = 27'(x) * 27'd5243;
      return p[25:19];
   endfunction

   // Quotient by 10 for values up to 99.
   function automatic logic [3:0] div10(input logic [6:0] x);
      logic [14:0] p;
      p = 15'(x) * 15'd205;
      return p[14:11];
   endfunction

   // Remainder by 10 for values up to 99.
   function automatic logic [3:0] mod10(input logic [6:0] x);
      logic [6:0] q;
      q = 7'(div10(x));
      return 4'(x - 7'(q * 7'd10));
   endfunction

endpackage

// ===== rtl/six_digit_seven_segment_scanner_core.sv =====
// ----------------------------------------------------------------------------
// six_digit_seven_segment_scanner_core
// Six-digit multiplexed seven-segment display driver with a stream interface.
// ----------------------------------------------------------------------------
// Every request transaction yields one response carrying the segment and
// digit-select latches as they stand after it. An enabled tick (op 0) moves
// the scan token one cell along the ring of six digit cells and latches that
// digit's pattern with its decimal point; loads (ops 1 to 3) rewrite the
// digits and the point mask, which show from the next tick. The core takes
// one transaction per clock cycle unless the response stalls; combinational
// decimal conversion feeds the digit cells and segment decode feeds the
// single response register, the only stage in the path. Writing 0 to the
// enable register stops scanning and turns all digit selects off at once.
module six_digit_seven_segment_scanner_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // left_value[15:0], right_value[31:16],
                                   // dot_mask[37:32], zero[39:38]
   input  logic [1:0]  req_tuser,  // op[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // segments[7:0], digit_select_n[13:8],
                                   // zero[15:14]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data    // display_enable
);
   import sdss_pkg::*;

   logic       req_accept;
   logic       csr_accept;
   op_type     op;
   load_type   load;
   logic       tick;

   logic       enable_ff;
   logic       enable_in;
   seg_type    seg_latch_ff;
   seg_type    seg_latch_in;
   mask_type   sel_latch_ff;
   mask_type   sel_latch_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic [15:0] rsp_data_ff;
   logic [15:0] rsp_data_in;

   mask_type   token;
   mask_type   token_next;
   seg_type    cell_seg [NUM_DIGITS];
   seg_type    seg_or;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid && csr_ready;
   assign op         = op_type'(req_tuser);
   assign tick       = req_accept && (op == OP_TICK) && enable_ff;

   sdss_digit_conv u_conv (
      .op          (op),
      .left_value  (req_tdata[15:0]),
      .right_value (req_tdata[31:16]),
      .dot_mask    (req_tdata[37:32]),
      .accept      (req_accept),
      .load        (load)
   );

   for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
      localparam int Prev = (i == 0) ? NUM_DIGITS - 1 : i - 1;
      assign token_next[i] = token[Prev];
      sdss_digit_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .reset_code  (RESET_CODES[i]),
         .reset_token (i == 0),
         .tick        (tick),
         .load        (load.load),
         .load_code   (load.codes[i]),
         .load_dot    (load.dots[i]),
         .token_in    (token[Prev]),
         .token_out   (token[i]),
         .seg_out     (cell_seg[i])
      );
   end

   always_comb begin
      seg_or = '0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         seg_or = seg_or | cell_seg[i];
      end
   end

   always_comb begin
      enable_in    = csr_accept ? csr_data : enable_ff;
      seg_latch_in = tick ? seg_or : seg_latch_ff;
      sel_latch_in = tick ? ~token_next : sel_latch_ff;
      if (csr_accept && !csr_data) begin
         sel_latch_in = ALL_OFF;
      end
      rsp_data_in  = req_accept ? {2'b00, sel_latch_in, seg_latch_in} : rsp_data_ff;
      rsp_valid_in = req_accept || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b1;
         seg_latch_ff <= '0;
         sel_latch_ff <= ALL_OFF;
         rsp_valid_ff <= 1'b0;
      end else begin
         enable_ff    <= enable_in;
         seg_latch_ff <= seg_latch_in;
         sel_latch_ff <= sel_latch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Exactly one cell holds the scan token.
   a_token_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(token))
      else $error("scan token is not held by exactly one cell");

   // At most one digit is selected at any time.
   a_select_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(~sel_latch_ff))
      else $error("more than one digit selected");

   // Disabling the display turns every digit off at the next edge.
   a_disable_off: assert property (@(posedge clock) disable iff (reset)
      csr_accept && !csr_data |=> sel_latch_ff == ALL_OFF)
      else $error("digit selects still active after disable");

   // An enabled tick without an enable write in the same cycle leaves the select latch pointing at the token holder.
   a_tick_select: assert property (@(posedge clock) disable iff (reset)
      tick && !csr_accept |=> sel_latch_ff == ~token)
      else $error("select latch does not follow the scan token");

endmodule

// ===== rtl/sdss_digit_conv.sv =====
// ----------------------------------------------------------------------------
// sdss_digit_conv
// Turns a load transaction into six digit codes and a point mask:
// saturation, decimal conversion and leading-zero blanking.
// ----------------------------------------------------------------------------
module sdss_digit_conv (
   input  sdss_pkg::op_type   op,
   input  logic [15:0]        left_value,
   input  logic [15:0]        right_value,
   input  sdss_pkg::mask_type dot_mask,
   input  logic               accept,
   output sdss_pkg::load_type load
);
   import sdss_pkg::*;

   logic [13:0] l4;
   logic [6:0]  r2;
   logic [9:0]  l3;
   logic [9:0]  r3;
   logic [6:0]  l4_hi;
   logic [6:0]  l4_lo;
   logic [6:0]  l3_hi;
   logic [6:0]  l3_lo;
   logic [6:0]  r3_hi;
   logic [6:0]  r3_lo;
   logic [3:0]  rh;
   logic [3:0]  rt;

   always_comb begin
      l4 = (left_value > 16'd9999) ? 14'd9999 : left_value[13:0];
      r2 = (right_value > 16'd99) ? 7'd99 : right_value[6:0];
      l3 = (left_value > 16'd999) ? 10'd999 : left_value[9:0];
      r3 = (right_value > 16'd999) ? 10'd999 : right_value[9:0];

      l4_hi = div100(l4);
      l4_lo = 7'(l4 - 14'(l4_hi) * 14'd100);
      l3_hi = div100(14'(l3));
      l3_lo = 7'(l3 - 10'(l3_hi) * 10'd100);
      r3_hi = div100(14'(r3));
      r3_lo = 7'(r3 - 10'(r3_hi) * 10'd100);
      rh    = 4'(r3_hi);
      rt    = div10(r3_lo);

      load.load  = accept && (op != OP_TICK);
      load.codes = RESET_CODES;
      load.dots  = dot_mask;

      unique case (op)
         OP_FOUR_TWO: begin
            load.codes[0] = code_type'(div10(l4_hi));
            load.codes[1] = code_type'(mod10(l4_hi));
            load.codes[2] = code_type'(div10(l4_lo));
            load.codes[3] = code_type'(mod10(l4_lo));
            load.codes[4] = code_type'(div10(r2));
            load.codes[5] = code_type'(mod10(r2));
         end
         OP_THREE_THREE: begin
            load.codes[0] = code_type'(l3_hi);
            load.codes[1] = code_type'(div10(l3_lo));
            load.codes[2] = code_type'(mod10(l3_lo));
            // The tens digit is blanked only behind a blanked hundreds digit.
            load.codes[3] = (rh == 4'd0) ? BLANK_CODE : code_type'(rh);
            load.codes[4] = (rh == 4'd0 && rt == 4'd0) ? BLANK_CODE : code_type'(rt);
            load.codes[5] = code_type'(mod10(r3_lo));
         end
         OP_BLANK_ZERO: begin
            load.codes = {5'd0, BLANK_CODE, BLANK_CODE, BLANK_CODE, BLANK_CODE,
                          BLANK_CODE};
            load.dots  = '0;
         end
         default: begin
            load.codes = RESET_CODES;
         end
      endcase
   end

endmodule

// ===== rtl/sdss_digit_cell.sv =====
// ----------------------------------------------------------------------------
// sdss_digit_cell
// One digit of the scan ring: holds a digit code, its point bit and the
// scan token, which moves on to the next cell at every enabled tick.
// ----------------------------------------------------------------------------
module sdss_digit_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  sdss_pkg::code_type   reset_code,
   input  logic                 reset_token,
   input  logic                 tick,
   input  logic                 load,
   input  sdss_pkg::code_type   load_code,
   input  logic                 load_dot,
   input  logic                 token_in,
   output logic                 token_out,
   output sdss_pkg::seg_type    seg_out
);
   import sdss_pkg::*;

   code_type code_ff;
   code_type code_in;
   logic     dot_ff;
   logic     dot_in;
   logic     token_ff;
   logic     token_in_d;

   always_comb begin
      code_in    = load ? load_code : code_ff;
      dot_in     = load ? load_dot : dot_ff;
      token_in_d = tick ? token_in : token_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff  <= reset_code;
         dot_ff   <= 1'b0;
         token_ff <= reset_token;
      end else begin
         code_ff  <= code_in;
         dot_ff   <= dot_in;
         token_ff <= token_in_d;
      end
   end

   assign token_out = token_ff;

   // The cell about to take the token drives the pattern for the next tick.
   assign seg_out = token_in ? (seg_decode(code_ff) | (dot_ff ? POINT_BIT : 8'h00))
                             : 8'h00;

endmodule

// ===== verif/six_digit_seven_segment_scanner_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// six_digit_seven_segment_scanner_core_tb
// Self-checking bench for the six-digit seven-segment scanner. A queue-fed
// driver sends ticks and digit loads, a shadow model of the digit store and
// scan latches predicts every response, and a monitor compares the segment
// and digit-select fields. Scanning is run enabled and disabled, with random
// idle gaps on both streams and a long response stall.
// ----------------------------------------------------------------------------
module six_digit_seven_segment_scanner_core_tb;
   import sdss_pkg::*;

   typedef struct {
      op_type      op;
      logic [15:0] left_val;
      logic [15:0] right_val;
      logic [5:0]  dots;
   } disp_cmd_type;

   typedef struct {
      logic [7:0] seg;
      logic [5:0] sel_n;
   } latch_type;

   // Segment patterns for codes 0 to 16, bit order b g c h d e f a from bit 0 up.
   localparam logic [7:0] SEG_PATTERN [17] = '{
      8'hF5, 8'h05, 8'hB3, 8'h97, 8'h47, 8'hD6, 8'hF6, 8'h85, 8'hF7, 8'hD7,
      8'h75, 8'h9F, 8'h00, 8'hDE, 8'hE3, 8'h02, 8'hE7
   };
   localparam int LONG_HOLD_CYCLES = 60;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic        csr_data   = 1'b0;

   six_digit_seven_segment_scanner_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   // Shadow copy of the display state.
   code_type digit_code [NUM_DIGITS];
   int       scan_pos;
   mask_type point_mask;
   seg_type  seg_q;
   mask_type sel_q;
   logic     scan_enable;

   disp_cmd_type pending_cmds [$];
   latch_type    expected_latches [$];
   disp_cmd_type cur_cmd;
   int        send_gap;
   int        rsp_stall;
   bit        no_idle = 1'b0;
   bit        long_hold_go = 1'b0;
   bit        long_hold_taken;
   int        errors;
   int        checked;
   int        op_count [4];
   int        csr_writes;
   int        disabled_ticks;

   function automatic seg_type digit_pattern(input code_type code);
      if (code < 5'd17) begin
         return SEG_PATTERN[code];
      end
      return 8'h00;
   endfunction

   // Applies one request to the shadow state and returns the latches after it.
   function automatic latch_type scanner_step(input disp_cmd_type c);
      int unsigned lv;
      int unsigned rv;
      int unsigned hund;
      int unsigned tens;
      latch_type   res;
      lv = c.left_val;
      rv = c.right_val;
      case (c.op)
         OP_TICK: begin
            if (scan_enable) begin
               scan_pos = (scan_pos == NUM_DIGITS - 1) ? 0 : scan_pos + 1;
               seg_q = digit_pattern(digit_code[scan_pos]);
               if (point_mask[scan_pos]) seg_q = seg_q | POINT_BIT;
               sel_q = ALL_OFF & ~(mask_type'(1) << scan_pos);
            end else begin
               disabled_ticks++;
            end
         end
         OP_FOUR_TWO: begin
            if (lv > 9999) lv = 9999;
            if (rv > 99) rv = 99;
            digit_code[0] = code_type'(lv / 1000);
            digit_code[1] = code_type'(lv / 100 % 10);
            digit_code[2] = code_type'(lv / 10 % 10);
            digit_code[3] = code_type'(lv % 10);
            digit_code[4] = code_type'(rv / 10);
            digit_code[5] = code_type'(rv % 10);
            point_mask = c.dots;
         end
         OP_THREE_THREE: begin
            if (lv > 999) lv = 999;
            if (rv > 999) rv = 999;
            hund = rv / 100;
            tens = rv / 10 % 10;
            digit_code[0] = code_type'(lv / 100);
            digit_code[1] = code_type'(lv / 10 % 10);
            digit_code[2] = code_type'(lv % 10);
            // The tens digit only blanks when the hundreds digit has blanked.
            digit_code[3] = (hund == 0) ? BLANK_CODE : code_type'(hund);
            digit_code[4] = (hund == 0 && tens == 0) ? BLANK_CODE : code_type'(tens);
            digit_code[5] = code_type'(rv % 10);
            point_mask = c.dots;
         end
         default: begin
            for (int i = 0; i < NUM_DIGITS - 1; i++) digit_code[i] = BLANK_CODE;
            digit_code[NUM_DIGITS-1] = '0;
            point_mask = '0;
         end
      endcase
      res.seg   = seg_q;
      res.sel_n = sel_q;
      return res;
   endfunction

   task automatic reset_model();
      digit_code[0] = 5'd14;
      digit_code[1] = 5'd15;
      digit_code[2] = 5'd1;
      digit_code[3] = 5'd6;
      digit_code[4] = 5'd1;
      digit_code[5] = 5'd0;
      scan_pos    = 0;
      point_mask  = '0;
      seg_q       = '0;
      sel_q       = ALL_OFF;
      scan_enable = 1'b1;
   endtask

   // Request driver: presents queued commands and inserts random idle gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_latches.push_back(scanner_step(cur_cmd));
            op_count[cur_cmd.op]++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               req_tvalid <= 1'b0;
               send_gap--;
            end else if (pending_cmds.size() > 0) begin
               cur_cmd = pending_cmds.pop_front();
               req_tdata  <= {2'b00, cur_cmd.dots, cur_cmd.right_val, cur_cmd.left_val};
               req_tuser  <= cur_cmd.op;
               req_tvalid <= 1'b1;
               if (!no_idle && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 9);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: checks each transaction and applies back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall = 0;
         long_hold_taken = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_latches.size() == 0) begin
               $error("unexpected response: segments %h, digit_select_n %h",
                      rsp_tdata[7:0], rsp_tdata[13:8]);
               errors++;
            end else begin
               latch_type want;
               want = expected_latches.pop_front();
               checked++;
               if (rsp_tdata[7:0] !== want.seg) begin
                  $error("segments: expected %h, got %h", want.seg, rsp_tdata[7:0]);
                  errors++;
               end
               if (rsp_tdata[13:8] !== want.sel_n) begin
                  $error("digit_select_n: expected %h, got %h", want.sel_n,
                         rsp_tdata[13:8]);
                  errors++;
               end
            end
         end
         if (long_hold_go && !long_hold_taken) begin
            long_hold_taken = 1'b1;
            rsp_stall = LONG_HOLD_CYCLES;
         end
         if (rsp_stall > 0) begin
            rsp_tready <= 1'b0;
            rsp_stall--;
         end else if (!no_idle && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            rsp_stall = $urandom_range(1, 9) - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic queue_cmd(input op_type op, input int unsigned l, input int unsigned r,
                            input int unsigned d);
      disp_cmd_type c;
      c.op        = op;
      c.left_val  = 16'(l);
      c.right_val = 16'(r);
      c.dots      = 6'(d);
      pending_cmds.push_back(c);
   endtask

   function automatic int unsigned pick_value(input int unsigned typical_max);
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 65535);
         1: return $urandom_range(0, typical_max);
         2: return $urandom_range(0, 20);
         default: return $urandom_range(0, 1200);
      endcase
   endfunction

   task automatic queue_random(input int n);
      int     r;
      op_type op;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 19);
         if (r < 12) op = OP_TICK;
         else if (r < 15) op = OP_FOUR_TWO;
         else if (r < 19) op = OP_THREE_THREE;
         else op = OP_BLANK_ZERO;
         queue_cmd(op, pick_value(9999), pick_value(999), $urandom_range(0, 63));
      end
   endtask

   // Waits until every queued command has been sent and answered.
   task automatic wait_drained();
      while (pending_cmds.size() > 0 || req_tvalid || expected_latches.size() > 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_enable(input logic value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      scan_enable = value;
      if (!value) sel_q = ALL_OFF;
      csr_writes++;
      csr_valid <= 1'b0;
   endtask

   initial begin
      reset_model();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_enable(1'b1);
      // Scan the power-on digits through a full wrap of the position.
      repeat (7) queue_cmd(OP_TICK, 0, 0, 0);
      // Both groups saturate, all points lit.
      queue_cmd(OP_FOUR_TWO, 65535, 65535, 63);
      repeat (3) queue_cmd(OP_TICK, 0, 0, 0);
      queue_cmd(OP_FOUR_TWO, 0, 0, 0);
      queue_cmd(OP_TICK, 0, 0, 0);
      // Right group zero: hundreds and tens blank, units shows 0.
      queue_cmd(OP_THREE_THREE, 65535, 0, 42);
      repeat (3) queue_cmd(OP_TICK, 0, 0, 0);
      // Tens digit of zero stays lit behind a non-zero hundreds digit.
      queue_cmd(OP_THREE_THREE, 7, 105, 21);
      repeat (3) queue_cmd(OP_TICK, 0, 0, 0);
      queue_cmd(OP_THREE_THREE, 999, 50, 0);
      queue_cmd(OP_BLANK_ZERO, 65535, 65535, 63);
      repeat (2) queue_cmd(OP_TICK, 0, 0, 0);
      wait_drained();

      // Random traffic with one long response stall while requests pile up.
      queue_random(150);
      repeat (20) @(posedge clock);
      long_hold_go <= 1'b1;
      wait_drained();

      write_enable(1'b0);
      queue_random(60);
      wait_drained();

      write_enable(1'b1);
      write_enable(1'b1);
      queue_random(150);
      wait_drained();

      no_idle <= 1'b1;
      queue_random(90);
      wait_drained();
      repeat (5) @(posedge clock);

      $display("Covered %0d ticks (%0d while disabled), %0d four-two, %0d three-three,",
               op_count[OP_TICK], disabled_ticks, op_count[OP_FOUR_TWO],
               op_count[OP_THREE_THREE]);
      $display("%0d blank-zero loads and %0d enable writes; %0d responses checked.",
               op_count[OP_BLANK_ZERO], csr_writes, checked);
      if (errors == 0 && expected_latches.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== six_digit_seven_segment_scanner_core.f =====
rtl/sdss_pkg.sv
rtl/sdss_digit_conv.sv
rtl/sdss_digit_cell.sv
rtl/six_digit_seven_segment_scanner_core.sv
verif/six_digit_seven_segment_scanner_core_tb.sv
